[hdl/toi_pkg.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// toi_pkg
// Shared beat types for the 2-opt route improver.
// ----------------------------------------------------------------------------
package toi_pkg;

    localparam int unsigned ID_W   = 6;
    localparam int unsigned IN_DW  = 16;

    localparam logic ACT_DIST = 1'b0;
    localparam logic ACT_NODE = 1'b1;

    typedef struct packed {
        logic             action;
        logic [ID_W-1:0]  from_node;
        logic [ID_W-1:0]  to_node;
        logic [IN_DW-1:0] distance;
        logic [ID_W-1:0]  route_node;
        logic             route_end;
    } in_beat_t;

    typedef struct packed {
        logic [ID_W-1:0] node;
        logic            last;
    } out_beat_t;

endpackage
`default_nettype wire

[hdl/two_opt_route_improver.sv]
`default_nettype none
// ----------------------------------------------------------------------------
// two_opt_route_improver
// First-improvement 2-opt search over one route held in on-chip memory.
// ----------------------------------------------------------------------------
// Usage: distance writes and route appends are each one start beat (start while
// busy is low). The beat flagged route_end raises busy; for a route of four
// nodes or more the block then runs 2-opt passes until a pass makes no change
// (at most PASS_LIMIT passes), and it streams the route out one node per cycle
// with out_valid; the receiver cannot stall, so every out_valid cycle is one
// delivered beat. Each pair compare steps through route reads, then distance
// reads through the single read port of each memory, one compare and one index
// step; a reversal swaps one node pair at a time (one route read port, one
// write port). Memories are not cleared: distances must be written before use.
module two_opt_route_improver #(
    parameter int unsigned NODE_COUNT = 64,
    parameter int unsigned ROUTE_MAX  = 64,
    parameter int unsigned DIST_WIDTH = 16
) (
    input  wire                 clk,
    input  wire                 rst_n,
    input  wire                 start,
    input  toi_pkg::in_beat_t   in_beat,
    output logic                busy,
    output logic                out_valid,
    output toi_pkg::out_beat_t  out_beat
);
    import toi_pkg::*;

    localparam int unsigned RW  = $clog2(ROUTE_MAX);
    localparam int unsigned CW  = RW + 1;
    localparam int unsigned PASS_LIMIT = 4096;
    localparam int unsigned PW  = 13;
    localparam int unsigned DEPTH = NODE_COUNT * NODE_COUNT;
    localparam int unsigned AW  = $clog2(DEPTH);

    typedef enum logic [10:0] {
        S_IDLE  = 11'b00000000001,
        S_PASS  = 11'b00000000010,
        S_RA    = 11'b00000000100,   // route reads a,b,c,e issued in turn
        S_DA    = 11'b00000001000,   // distance reads issued in turn
        S_CMP   = 11'b00000010000,
        S_RVRD  = 11'b00000100000,   // reversal: read lo
        S_RVRD2 = 11'b00001000000,   // read hi, latch lo
        S_RVWR  = 11'b00010000000,   // latch hi, write lo
        S_RVWR2 = 11'b00100000000,   // write hi
        S_NEXT  = 11'b01000000000,
        S_EMIT  = 11'b10000000000
    } st_t;

    st_t st_reg, st_next;

    // Memories
    logic [DIST_WIDTH-1:0] dmem [DEPTH];
    logic [ID_W-1:0]       rmem [ROUTE_MAX];
    logic [DIST_WIDTH-1:0] drd;
    logic [ID_W-1:0]       rrd;

    logic          dwe;
    logic [AW-1:0] dwa, dra;
    logic          rwe;
    logic [RW-1:0] rwa, rra;
    logic [ID_W-1:0] rwd;

    always_ff @(posedge clk)
    begin
        if (dwe)
            dmem[dwa] <= DIST_WIDTH'(in_beat.distance);
        drd <= dmem[dra];
    end

    always_ff @(posedge clk)
    begin
        if (rwe)
            rmem[rwa] <= rwd;
        rrd <= rmem[rra];
    end

    logic [CW-1:0]   cnt_reg;
    logic [RW-1:0]   i_reg, j_reg, lo_reg, hi_reg, k_reg;
    logic [2:0]      ph_reg;
    logic [ID_W-1:0] na_reg, nb_reg, nc_reg, ne_reg, tlo_reg, thi_reg;
    logic [DIST_WIDTH:0] s1_reg, s2_reg;
    logic            imp_reg;
    logic [PW-1:0]   pass_reg;
    logic            kv_reg;   // emission: read data for k is valid

    logic in_acc;
    assign in_acc = start && (st_reg == S_IDLE);
    assign busy   = (st_reg != S_IDLE);

    logic [CW-1:0] n_val;
    assign n_val = cnt_reg - CW'(1);

    // Emission reads one address ahead: once data for k is valid, the read
    // targets k+1.
    logic [RW-1:0] k_rd;
    assign k_rd = k_reg + RW'(kv_reg);

    function automatic logic [AW-1:0] daddr(input logic [ID_W-1:0] a,
                                            input logic [ID_W-1:0] b);
        logic [2*ID_W+8:0] t;
        t = (2*ID_W+9)'(a) * (2*ID_W+9)'(NODE_COUNT) + (2*ID_W+9)'(b);
        return t[AW-1:0];
    endfunction

    logic a_ok, b_ok, c_ok, e_ok;
    assign a_ok = 32'(na_reg) < NODE_COUNT;
    assign b_ok = 32'(nb_reg) < NODE_COUNT;
    assign c_ok = 32'(nc_reg) < NODE_COUNT;
    assign e_ok = 32'(ne_reg) < NODE_COUNT;

    // Memory port steering
    always_comb
    begin
        dwe = in_acc && (in_beat.action == ACT_DIST)
              && (32'(in_beat.from_node) < NODE_COUNT)
              && (32'(in_beat.to_node) < NODE_COUNT);
        dwa = daddr(in_beat.from_node, in_beat.to_node);
        rwe = 1'b0;
        rwa = cnt_reg[RW-1:0];
        rwd = in_beat.route_node;
        rra = i_reg;
        dra = daddr(na_reg, nb_reg);
        if (in_acc && in_beat.action == ACT_NODE && 32'(cnt_reg) < ROUTE_MAX)
            rwe = 1'b1;
        unique case (ph_reg)
            3'd0:    dra = daddr(na_reg, nb_reg);
            3'd1:    dra = daddr(nc_reg, ne_reg);
            3'd2:    dra = daddr(na_reg, nc_reg);
            default: dra = daddr(nb_reg, ne_reg);
        endcase
        priority case (1'b1)
            st_reg == S_RA:
                unique case (ph_reg)
                    3'd0:    rra = i_reg;
                    3'd1:    rra = i_reg + RW'(1);
                    3'd2:    rra = j_reg;
                    default: rra = j_reg + RW'(1);
                endcase
            st_reg == S_RVRD:  rra = lo_reg;
            st_reg == S_RVRD2: rra = hi_reg;
            st_reg == S_RVWR:
            begin
                rwe = 1'b1; rwa = lo_reg; rwd = thi_reg;
            end
            st_reg == S_RVWR2:
            begin
                rwe = 1'b1; rwa = hi_reg; rwd = tlo_reg;
            end
            st_reg == S_EMIT:  rra = k_rd;
            default: ;
        endcase
        // hi value arrives during S_RVWR; use it directly for the lo write
        if (st_reg == S_RVWR)
            rwd = rrd;
    end

    logic emit_last;
    assign emit_last = kv_reg && (CW'(k_reg) + CW'(1) == cnt_reg);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg   <= S_IDLE;
            cnt_reg  <= '0;
            i_reg    <= '0;
            j_reg    <= '0;
            ph_reg   <= '0;
            imp_reg  <= 1'b0;
            pass_reg <= '0;
            kv_reg   <= 1'b0;
            lo_reg   <= '0;
            hi_reg   <= '0;
            k_reg    <= '0;
        end
        else
        begin
            st_reg <= st_next;
            unique case (st_reg)
                S_IDLE:
                begin
                    if (in_acc && in_beat.action == ACT_NODE)
                    begin
                        if (32'(cnt_reg) < ROUTE_MAX)
                            cnt_reg <= cnt_reg + CW'(1);
                        pass_reg <= '0;
                        k_reg    <= '0;
                        kv_reg   <= 1'b0;
                    end
                end
                S_PASS:
                begin
                    imp_reg  <= 1'b0;
                    pass_reg <= pass_reg + PW'(1);
                    i_reg    <= '0;
                    j_reg    <= RW'(2);
                    ph_reg   <= '0;
                end
                S_RA:
                begin
                    // read issued at ph, data back next cycle
                    if (ph_reg == 3'd4)
                        ph_reg <= '0;
                    else
                        ph_reg <= ph_reg + 3'd1;
                end
                S_DA:
                    ph_reg <= ph_reg + 3'd1;
                S_CMP:
                begin
                    ph_reg <= '0;
                    if (s1_reg > s2_reg)
                    begin
                        imp_reg <= 1'b1;
                        lo_reg  <= i_reg + RW'(1);
                        hi_reg  <= j_reg;
                    end
                end
                S_RVWR2:
                begin
                    lo_reg <= lo_reg + RW'(1);
                    hi_reg <= hi_reg - RW'(1);
                end
                S_NEXT:
                begin
                    if (CW'(j_reg) + CW'(1) < n_val)
                        j_reg <= j_reg + RW'(1);
                    else
                    begin
                        i_reg <= i_reg + RW'(1);
                        j_reg <= i_reg + RW'(3);
                    end
                end
                S_EMIT:
                begin
                    if (kv_reg)
                        k_reg <= k_reg + RW'(1);
                    if (emit_last)
                    begin
                        cnt_reg <= '0;
                        kv_reg  <= 1'b0;
                    end
                    else
                        kv_reg <= 1'b1;
                end
                default: ;
            endcase
        end
    end

    // Datapath captures
    always_ff @(posedge clk)
    begin
        if (st_reg == S_RA)
        begin
            unique case (ph_reg)
                3'd1:    na_reg <= rrd;
                3'd2:    nb_reg <= rrd;
                3'd3:    nc_reg <= rrd;
                3'd4:    ne_reg <= rrd;
                default: ;
            endcase
        end
        if (st_reg == S_DA)
        begin
            unique case (ph_reg)
                3'd1: s1_reg <= (DIST_WIDTH+1)'(a_ok && b_ok ? drd : '0);
                3'd2: s1_reg <= s1_reg + (DIST_WIDTH+1)'(c_ok && e_ok ? drd : '0);
                3'd3: s2_reg <= (DIST_WIDTH+1)'(a_ok && c_ok ? drd : '0);
                3'd4: s2_reg <= s2_reg + (DIST_WIDTH+1)'(b_ok && e_ok ? drd : '0);
                default: ;
            endcase
        end
        if (st_reg == S_RVRD2)
            tlo_reg <= rrd;
        if (st_reg == S_RVWR)
            thi_reg <= rrd;
    end

    // Next state
    always_comb
    begin
        st_next = st_reg;
        unique case (st_reg)
            S_IDLE:
                if (in_acc && in_beat.action == ACT_NODE && in_beat.route_end)
                begin
                    if (32'(cnt_reg) + ((32'(cnt_reg) < ROUTE_MAX) ? 1 : 0) >= 4)
                        st_next = S_PASS;
                    else
                        st_next = S_EMIT;
                end
            S_PASS:  st_next = S_RA;
            S_RA:    if (ph_reg == 3'd4) st_next = S_DA;
            S_DA:    if (ph_reg == 3'd4) st_next = S_CMP;
            S_CMP:   st_next = (s1_reg > s2_reg) ? S_RVRD : S_NEXT;
            S_RVRD:  st_next = (lo_reg < hi_reg) ? S_RVRD2 : S_NEXT;
            S_RVRD2: st_next = S_RVWR;
            S_RVWR:  st_next = S_RVWR2;
            S_RVWR2: st_next = S_RVRD;
            S_NEXT:
                if (CW'(j_reg) + CW'(1) < n_val)
                    st_next = S_RA;
                else if (CW'(i_reg) + CW'(3) < n_val)
                    st_next = S_RA;
                else if (imp_reg && 32'(pass_reg) < PASS_LIMIT)
                    st_next = S_PASS;
                else
                    st_next = S_EMIT;
            S_EMIT:  if (emit_last) st_next = S_IDLE;
            default: st_next = S_IDLE;
        endcase
    end

    assign out_valid     = (st_reg == S_EMIT) && kv_reg;
    assign out_beat.node = rrd;
    assign out_beat.last = emit_last;

endmodule
`default_nettype wire
